// ===== rtl/gpat_pkg.sv =====
// Shared types and constants for the gameport axis pulse timer.
package gpat_pkg;

    localparam int unsigned NumAxes   = 4;
    localparam int unsigned TickW     = 16;
    localparam int unsigned PortW     = 8;
    localparam int unsigned InDataW   = 32;
    localparam int unsigned OutDataW  = 72;

    localparam logic [TickW-1:0] SatTicks = 16'hFFFF;
    localparam logic [PortW-1:0] ByteMask = 8'hFF;

    localparam logic ReqStart  = 1'b0;
    localparam logic ReqSample = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [NumAxes-1:0]     axis_select;
        logic [PortW-1:0]       port_value;
        logic [TickW-1:0]       timer_now;
    } in_item_t;

    typedef struct packed {
        logic [TickW-1:0]       axis3_time;
        logic [TickW-1:0]       axis2_time;
        logic [TickW-1:0]       axis1_time;
        logic [TickW-1:0]       axis0_time;
        logic [PortW-1:0]       button_bits;
        logic                   timed_out;
    } result_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== rtl/gameport_axis_pulse_timer_top.sv =====
// Top level of the gameport axis pulse timer.
//
// Slave stream: one beat per start or port sample; tuser selects the kind
// (0 start, 1 sample). A start arms the axes in its mask and records the
// timer; each sample folds the port byte into the button bits, latches the
// elapsed time of every armed axis that fell, and adds the timer delta.
// Master stream: one beat when the last armed axis falls or the elapsed time
// saturates at 65535; tuser then flags the timeout.
// Config channel: writes the timer reload (0 means 65536); write it only
// while no measurement runs.
// An accepted sample passes the input register and the update logic, and
// its result beat is held in the result register. Throughput: one beat
// per cycle while the master side is not stalled, with one state update
// per beat. A stalled master side holds the result register; the input
// register keeps taking beats until one is waiting behind it.
// Reset: disarms all axes, clears readings and reload, buttons all ones.
module gameport_axis_pulse_timer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // axis_select[3:0], port_value[11:4], timer_now[27:12]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // axis0..axis3_time[63:0], button_bits[71:64]
    output logic        m_tuser,   // timed_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // timer_reload
);

    gpat_pkg::in_item_t   item;
    logic                 item_valid;
    logic                 advance;
    logic                 res_valid;
    gpat_pkg::result_t    res;
    gpat_pkg::stage_ctl_t ctl;

    assign cfg_ready   = 1'b1;
    assign ctl.valid   = item_valid;
    assign ctl.advance = advance;

    gpat_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    gpat_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    gpat_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/gpat_in_reg.sv =====
// Input register stage: captures one sample or start beat.
module gpat_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               advance,
    output gpat_pkg::in_item_t item,
    output logic               item_valid
);

    logic               valid_reg;
    logic               valid_next;
    gpat_pkg::in_item_t item_reg;
    logic               accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type    <= s_tuser;
            item_reg.axis_select <= s_tdata[3:0];
            item_reg.port_value  <= s_tdata[11:4];
            item_reg.timer_now   <= s_tdata[27:12];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== rtl/gpat_core.sv =====
// Measurement state and per-beat update logic.
module gpat_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [15:0]         cfg_data,
    input  gpat_pkg::stage_ctl_t ctl,
    input  gpat_pkg::in_item_t  item,
    output logic                res_valid,
    output gpat_pkg::result_t   res
);

    logic [gpat_pkg::TickW-1:0]   reload_reg;
    logic [gpat_pkg::NumAxes-1:0] pending_reg;
    logic [gpat_pkg::NumAxes-1:0] pending_next;
    logic [gpat_pkg::TickW-1:0]   elapsed_reg;
    logic [gpat_pkg::TickW-1:0]   elapsed_next;
    logic [gpat_pkg::TickW-1:0]   last_reg;
    logic [gpat_pkg::TickW-1:0]   last_next;
    logic [gpat_pkg::TickW-1:0]   axis_reg  [gpat_pkg::NumAxes];
    logic [gpat_pkg::TickW-1:0]   axis_next [gpat_pkg::NumAxes];
    logic [gpat_pkg::PortW-1:0]   button_reg;
    logic [gpat_pkg::PortW-1:0]   button_next;

    logic                         fire;
    logic [gpat_pkg::NumAxes-1:0] fell;
    logic [gpat_pkg::NumAxes-1:0] left;
    logic [gpat_pkg::TickW-1:0]   delta;
    logic [gpat_pkg::TickW:0]     total;
    logic                         timeout;

    assign fire  = ctl.valid && ctl.advance;
    assign fell  = ~item.port_value[gpat_pkg::NumAxes-1:0] & pending_reg;
    assign left  = pending_reg & ~fell;
    assign delta = (item.timer_now > last_reg)
                 ? last_reg + reload_reg - item.timer_now
                 : last_reg - item.timer_now;
    assign total   = {1'b0, elapsed_reg} + {1'b0, delta};
    assign timeout = total[gpat_pkg::TickW];

    always_comb
    begin
        pending_next = pending_reg;
        elapsed_next = elapsed_reg;
        last_next    = last_reg;
        button_next  = button_reg;
        for (int i = 0; i < gpat_pkg::NumAxes; i++)
            axis_next[i] = axis_reg[i];
        res_valid    = 1'b0;
        res.timed_out = 1'b0;

        if (fire)
        begin
            if (item.req_type == gpat_pkg::ReqStart)
            begin
                if (item.axis_select != '0)
                begin
                    pending_next = item.axis_select;
                    elapsed_next = '0;
                    last_next    = item.timer_now;
                    button_next  = gpat_pkg::ByteMask;
                end
            end
            else if (pending_reg != '0)
            begin
                button_next = button_reg & item.port_value;
                for (int i = 0; i < gpat_pkg::NumAxes; i++)
                    if (fell[i])
                        axis_next[i] = elapsed_reg;
                pending_next = left;
                if (left == '0)
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    last_next = item.timer_now;
                    if (timeout)
                    begin
                        elapsed_next = gpat_pkg::SatTicks;
                        for (int i = 0; i < gpat_pkg::NumAxes; i++)
                            if (left[i])
                                axis_next[i] = gpat_pkg::SatTicks;
                        pending_next  = '0;
                        res_valid     = 1'b1;
                        res.timed_out = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = total[gpat_pkg::TickW-1:0];
                    end
                end
            end
        end

        res.axis0_time  = axis_next[0];
        res.axis1_time  = axis_next[1];
        res.axis2_time  = axis_next[2];
        res.axis3_time  = axis_next[3];
        res.button_bits = button_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg  <= '0;
            pending_reg <= '0;
            elapsed_reg <= '0;
            last_reg    <= '0;
            button_reg  <= gpat_pkg::ByteMask;
            for (int i = 0; i < gpat_pkg::NumAxes; i++)
                axis_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
                reload_reg <= cfg_data;
            pending_reg <= pending_next;
            elapsed_reg <= elapsed_next;
            last_reg    <= last_next;
            button_reg  <= button_next;
            for (int i = 0; i < gpat_pkg::NumAxes; i++)
                axis_reg[i] <= axis_next[i];
        end
    end

endmodule

// ===== rtl/gpat_out_reg.sv =====
// Result register stage driving the master-side stream.
module gpat_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  gpat_pkg::result_t res,
    output logic              advance,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,
    output logic              m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    gpat_pkg::result_t res_reg;

    assign advance = !valid_reg || m_tready;

    always_comb
    begin
        if (advance)
            valid_next = res_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.button_bits, res_reg.axis3_time, res_reg.axis2_time,
                       res_reg.axis1_time, res_reg.axis0_time};
    assign m_tuser  = res_reg.timed_out;

endmodule
